[rtl/rtpc_pkg.sv]
package rtpc_pkg;

   // configuration register map
   localparam int CSR_ADDR_W  = 3;
   localparam int CSR_DATA_W  = 32;
   localparam logic [0:0] REG_LINK_KIND = 1'd0;

   localparam int SNAP_LIMIT_DEFAULT = 65535;
   localparam int QUEUE_DEPTH = 2;

   // link kinds
   localparam logic [2:0] LINK_ETHERNET = 3'd0;
   localparam logic [2:0] LINK_COOKED   = 3'd1;
   localparam logic [2:0] LINK_RAW_IP   = 3'd2;
   localparam logic [2:0] LINK_NULL     = 3'd3;

   // verdict codes
   localparam logic [3:0] VERDICT_ACCEPTED   = 4'd0;
   localparam logic [3:0] VERDICT_BAD_LINK   = 4'd1;
   localparam logic [3:0] VERDICT_SHORT_LINK = 4'd2;
   localparam logic [3:0] VERDICT_SHORT_IP   = 4'd3;
   localparam logic [3:0] VERDICT_SHORT_UDP  = 4'd4;
   localparam logic [3:0] VERDICT_NOT_UDP    = 4'd5;
   localparam logic [3:0] VERDICT_UDP_LEN    = 4'd6;
   localparam logic [3:0] VERDICT_SHORT_PAY  = 4'd7;
   localparam logic [3:0] VERDICT_NOT_RTP2   = 4'd8;

   localparam logic [7:0] PROTO_UDP     = 8'd17;
   localparam logic [7:0] RTP_VER_MASK  = 8'hC0;
   localparam logic [7:0] RTP_VER_TWO   = 8'h80;
   localparam logic [7:0] IHL_MASK      = 8'h0F;
   localparam logic [15:0] UDP_HDR_LEN  = 16'd8;
   localparam logic [15:0] RTP_HDR_LEN  = 16'd12;
   localparam logic [9:0] NSEC_PER_USEC = 10'd1000;

   // frame length kept for checks; every threshold is below this
   localparam logic [6:0] LEN_CLIP = 7'd127;

   typedef struct packed {
      logic [7:0]  data_byte;
      logic        last_byte;
      logic [31:0] stamp_sec;
      logic [19:0] stamp_usec;
   } req_type;

   typedef struct packed {
      logic [3:0]  verdict;
      logic        accepted;
      logic [6:0]  payload_start;
      logic [15:0] payload_length;
      logic [31:0] out_sec;
      logic [29:0] out_nsec;
   } rsp_type;

   typedef struct packed {
      logic       ok;
      logic [4:0] offset;
   } link_info_type;

   // one finished frame, waiting for its verdict
   typedef struct packed {
      link_info_type link;
      logic [6:0]    frame_len;
      logic [5:0]    ihl;
      logic [7:0]    protocol;
      logic [15:0]   udp_length;
      logic [7:0]    rtp_first;
      logic [31:0]   stamp_sec;
      logic [19:0]   stamp_usec;
   } rec_type;

   function automatic link_info_type link_decode(input logic [2:0] kind);
      link_info_type res;
      res.ok = 1'b1;
      unique case (kind)
         LINK_ETHERNET: res.offset = 5'd14;
         LINK_COOKED:   res.offset = 5'd16;
         LINK_RAW_IP:   res.offset = 5'd0;
         LINK_NULL:     res.offset = 5'd4;
         default: begin
            res.ok = 1'b0;
            res.offset = 5'd0;
         end
      endcase
      return res;
   endfunction

endpackage

[rtl/rtpc_front.sv]
module rtpc_front #(
   parameter int SNAP_LIMIT = rtpc_pkg::SNAP_LIMIT_DEFAULT
) (
   input  logic              clock,
   input  logic              reset,
   input  logic [2:0]        link_kind,
   input  logic              in_valid,
   output logic              in_ready,
   input  rtpc_pkg::req_type in_data,
   output logic              push_valid,
   input  logic              push_ready,
   output rtpc_pkg::rec_type push_data
);
   import rtpc_pkg::*;

   logic [15:0] count_ff, count_in;
   logic [5:0]  ihl_ff, ihl_in;
   logic [7:0]  proto_ff, proto_in;
   logic [15:0] udp_ff, udp_in;
   logic [7:0]  rtp_ff, rtp_in;

   link_info_type link;
   logic [15:0]   pos_o, pos_udp;
   logic [15:0]   len;
   logic          take;

   assign link     = link_decode(link_kind);
   assign in_ready = push_ready;
   assign take     = in_valid && in_ready;

   assign pos_o   = {11'd0, link.offset};
   assign pos_udp = pos_o + {10'd0, ihl_ff};

   assign len = (count_ff >= 16'(SNAP_LIMIT)) ? 16'(SNAP_LIMIT) : count_ff + 16'd1;

   always_comb begin
      ihl_in   = ihl_ff;
      proto_in = proto_ff;
      udp_in   = udp_ff;
      rtp_in   = rtp_ff;
      if (link.ok) begin
         if (count_ff == pos_o) begin
            ihl_in = {in_data.data_byte[3:0] & IHL_MASK[3:0], 2'b00};
         end
         if (count_ff == pos_o + 16'd9) begin
            proto_in = in_data.data_byte;
         end
         if (count_ff == pos_udp + 16'd4) begin
            udp_in[15:8] = in_data.data_byte;
         end
         if (count_ff == pos_udp + 16'd5) begin
            udp_in[7:0] = in_data.data_byte;
         end
         if (count_ff == pos_udp + 16'd8) begin
            rtp_in = in_data.data_byte;
         end
      end
      count_in = len;
   end

   always_comb begin
      push_valid           = take && in_data.last_byte;
      push_data.link       = link;
      push_data.frame_len  = (len > {9'd0, LEN_CLIP}) ? LEN_CLIP : len[6:0];
      push_data.ihl        = ihl_in;
      push_data.protocol   = proto_in;
      push_data.udp_length = udp_in;
      push_data.rtp_first  = rtp_in;
      push_data.stamp_sec  = in_data.stamp_sec;
      push_data.stamp_usec = in_data.stamp_usec;
   end

   always_ff @(posedge clock) begin
      if (reset || (take && in_data.last_byte)) begin
         count_ff <= '0;
         ihl_ff   <= '0;
         proto_ff <= '0;
         udp_ff   <= '0;
         rtp_ff   <= '0;
      end else if (take) begin
         count_ff <= count_in;
         ihl_ff   <= ihl_in;
         proto_ff <= proto_in;
         udp_ff   <= udp_in;
         rtp_ff   <= rtp_in;
      end
   end

endmodule

[rtl/rtpc_queue.sv]
module rtpc_queue (
   input  logic              clock,
   input  logic              reset,
   input  logic              push_valid,
   output logic              push_ready,
   input  rtpc_pkg::rec_type push_data,
   output logic              pop_valid,
   input  logic              pop_ready,
   output rtpc_pkg::rec_type pop_data
);
   import rtpc_pkg::*;

   localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

   rec_type            slot_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff, rd_ptr_ff;
   logic [CNT_W-1:0]   fill_ff, fill_in;
   logic               do_push, do_pop;

   assign push_ready = (fill_ff != CNT_W'(QUEUE_DEPTH));
   assign pop_valid  = (fill_ff != '0);
   assign pop_data   = slot_ff[rd_ptr_ff];
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop_valid && pop_ready;

   always_comb begin
      fill_in = fill_ff;
      if (do_push && !do_pop) begin
         fill_in = fill_ff + CNT_W'(1);
      end else if (do_pop && !do_push) begin
         fill_in = fill_ff - CNT_W'(1);
      end
   end

   function automatic logic [PTR_W-1:0] bump(input logic [PTR_W-1:0] p);
      return (p == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + PTR_W'(1);
   endfunction

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
      end else begin
         fill_ff <= fill_in;
         if (do_push) begin
            wr_ptr_ff <= bump(wr_ptr_ff);
         end
         if (do_pop) begin
            rd_ptr_ff <= bump(rd_ptr_ff);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

[rtl/rtpc_back.sv]
module rtpc_back (
   input  logic              clock,
   input  logic              reset,
   input  logic              pop_valid,
   output logic              pop_ready,
   input  rtpc_pkg::rec_type pop_data,
   output logic              out_valid,
   input  logic              out_ready,
   output rtpc_pkg::rsp_type out_data
);
   import rtpc_pkg::*;

   logic    valid_ff;
   rsp_type rsp_ff, rsp_in;

   logic [6:0]  o, o_ip, o_pay, o_rtp, o_proto;
   logic [15:0] plen;
   logic [3:0]  verdict;
   logic        keep_pay;

   assign o       = {2'b00, pop_data.link.offset};
   assign o_ip    = o + 7'd2;
   assign o_proto = o + 7'd10;
   assign o_pay   = o + {1'b0, pop_data.ihl} + 7'd8;
   assign o_rtp   = o_pay + 7'd1;
   assign plen    = pop_data.udp_length - UDP_HDR_LEN;

   always_comb begin
      keep_pay = 1'b0;
      priority if (!pop_data.link.ok) begin
         verdict = VERDICT_BAD_LINK;
      end else if (pop_data.frame_len < o) begin
         verdict = VERDICT_SHORT_LINK;
      end else if (pop_data.frame_len < o_ip) begin
         verdict = VERDICT_SHORT_IP;
      end else if (pop_data.frame_len < o_pay) begin
         verdict = VERDICT_SHORT_UDP;
      end else if (pop_data.frame_len < o_proto) begin
         // header length nibble of zero: protocol byte never arrived
         verdict = VERDICT_SHORT_IP;
      end else if (pop_data.protocol != PROTO_UDP) begin
         verdict = VERDICT_NOT_UDP;
      end else if (pop_data.udp_length < UDP_HDR_LEN) begin
         verdict = VERDICT_UDP_LEN;
      end else if (plen < RTP_HDR_LEN) begin
         verdict  = VERDICT_SHORT_PAY;
         keep_pay = 1'b1;
      end else if (pop_data.frame_len < o_rtp) begin
         verdict = VERDICT_SHORT_UDP;
      end else if ((pop_data.rtp_first & RTP_VER_MASK) != RTP_VER_TWO) begin
         verdict  = VERDICT_NOT_RTP2;
         keep_pay = 1'b1;
      end else begin
         verdict  = VERDICT_ACCEPTED;
         keep_pay = 1'b1;
      end
   end

   always_comb begin
      rsp_in.verdict        = verdict;
      rsp_in.accepted       = (verdict == VERDICT_ACCEPTED);
      rsp_in.payload_start  = keep_pay ? o_pay : 7'd0;
      rsp_in.payload_length = keep_pay ? plen : 16'd0;
      rsp_in.out_sec        = pop_data.stamp_sec;
      rsp_in.out_nsec       = 30'(pop_data.stamp_usec * NSEC_PER_USEC);
   end

   assign pop_ready = !valid_ff || out_ready;
   assign out_valid = valid_ff;
   assign out_data  = rsp_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (pop_ready) begin
         valid_ff <= pop_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (pop_ready && pop_valid) begin
         rsp_ff <= rsp_in;
      end
   end

endmodule

[rtl/rtp_over_udp_packet_classifier.sv]
// Path: after its last byte is taken, a frame's record is written into the
//   frame queue; its verdict is then held in the verdict/output register.
// Throughput: one byte per cycle while the 2-entry frame queue has room; it
//   lets the byte side keep streaming while a verdict waits on rsp_ready.
// Reset (synchronous, active high): link_kind returns to ethernet, the byte
//   counter and captured header fields clear, queue and output empty.
module rtp_over_udp_packet_classifier #(
   parameter int SNAP_LIMIT = rtpc_pkg::SNAP_LIMIT_DEFAULT
) (
   input  logic                            clock,
   input  logic                            reset,

   // request channel: one frame byte per request
   input  logic                            req_valid,
   output logic                            req_ready,
   input  rtpc_pkg::req_type               req_data,

   // response channel: one verdict per frame
   output logic                            rsp_valid,
   input  logic                            rsp_ready,
   output rtpc_pkg::rsp_type               rsp_data,

   // register port
   input  logic                            csr_psel,
   input  logic                            csr_penable,
   input  logic                            csr_pwrite,
   input  logic [rtpc_pkg::CSR_ADDR_W-1:0] csr_paddr,
   input  logic [rtpc_pkg::CSR_DATA_W-1:0] csr_pwdata,
   output logic [rtpc_pkg::CSR_DATA_W-1:0] csr_prdata,
   output logic                            csr_pready
);
   import rtpc_pkg::*;

   logic [2:0] link_kind_ff;
   logic       csr_hit;

   logic    push_valid, push_ready;
   rec_type push_data;
   logic    pop_valid, pop_ready;
   rec_type pop_data;

   // --- register file: a single word, link_kind at byte address 0 ---
   assign csr_pready = 1'b1;
   assign csr_hit    = (csr_paddr[CSR_ADDR_W-1:2] == REG_LINK_KIND);

   always_ff @(posedge clock) begin
      if (reset) begin
         link_kind_ff <= LINK_ETHERNET;
      end else if (csr_psel && csr_penable && csr_pwrite && csr_pready && csr_hit) begin
         link_kind_ff <= csr_pwdata[2:0];
      end
   end

   assign csr_prdata = csr_hit ? {29'd0, link_kind_ff} : '0;

   // --- front: counts bytes, grabs IHL, protocol, UDP length, first RTP byte ---
   rtpc_front #(
      .SNAP_LIMIT (SNAP_LIMIT)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .link_kind  (link_kind_ff),
      .in_valid   (req_valid),
      .in_ready   (req_ready),
      .in_data    (req_data),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_data  (push_data)
   );

   // --- queue of finished frames between the two halves ---
   rtpc_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_data  (push_data),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_data   (pop_data)
   );

   // --- back: ordered checks, payload fields, usec to nsec, output register ---
   rtpc_back u_back (
      .clock     (clock),
      .reset     (reset),
      .pop_valid (pop_valid),
      .pop_ready (pop_ready),
      .pop_data  (pop_data),
      .out_valid (rsp_valid),
      .out_ready (rsp_ready),
      .out_data  (rsp_data)
   );

endmodule
